FILE: hdl/c8x_pkg.sv
// ----------------------------------------------------------------------------
// c8x_pkg: shared types and constants of the CHIP-8 execute core
// Request codes, status codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package c8x_pkg;

   localparam int MemBytesDef   = 4096;
   localparam int StackDepthDef = 16;
   localparam int StartAddrDef  = 512;

   localparam int AddrW = 12;
   localparam int ByteW = 8;

   typedef enum logic [1:0] {
      REQ_MEM_WRITE = 2'd0,
      REQ_MEM_READ  = 2'd1,
      REQ_EXECUTE   = 2'd2,
      REQ_REG_READ  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNIMPL    = 2'd1,
      ST_OVERFLOW  = 2'd2,
      ST_UNDERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [AddrW-1:0] address;
      logic [ByteW-1:0] write_data;
      logic [3:0]       reg_index;
      logic [ByteW-1:0] random_byte;
   } req_item_type;

   typedef struct packed {
      logic [ByteW-1:0] read_data;
      logic [AddrW-1:0] pc_value;
      logic [AddrW-1:0] index_value;
      logic [ByteW-1:0] delay_value;
      logic [ByteW-1:0] sound_value;
      logic [1:0]       status;
   } rsp_item_type;

   // memory port request from the sequencer
   typedef struct packed {
      logic             wr;
      logic [AddrW-1:0] addr;
      logic [ByteW-1:0] wdata;
   } mem_cmd_type;

endpackage

FILE: hdl/c8x_if.sv
// ----------------------------------------------------------------------------
// c8x_req_if / c8x_rsp_if: valid/ready channels of the CHIP-8 execute core
// One interface per direction, each carrying its payload struct.
// ----------------------------------------------------------------------------
interface c8x_req_if import c8x_pkg::*; ();
   logic         valid;
   logic         ready;
   req_item_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface c8x_rsp_if import c8x_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/c8x_mem.sv
// ----------------------------------------------------------------------------
// c8x_mem: program memory with clearing sweep
// Single port byte RAM, registered read; clears itself after reset.
// ----------------------------------------------------------------------------
module c8x_mem import c8x_pkg::*; #(
   parameter int MEM_BYTES = MemBytesDef
) (
   input  logic             clock,
   input  logic             reset,
   input  mem_cmd_type      cmd,
   input  logic             cmd_en,
   output logic [ByteW-1:0] rdata,
   output logic             clear_done
);
   localparam int AW = $clog2(MEM_BYTES);

   logic [ByteW-1:0] mem [MEM_BYTES];
   logic [AW:0]      clr_ff, clr_in;
   logic [ByteW-1:0] rdata_ff;

   assign clear_done = clr_ff[AW];
   assign clr_in     = clear_done ? clr_ff : clr_ff + 1'b1;

   // advance clear pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   // write or clear, registered read
   always_ff @(posedge clock) begin
      if (!clear_done) begin
         mem[clr_ff[AW-1:0]] <= '0;
      end else if (cmd_en && cmd.wr) begin
         mem[cmd.addr[AW-1:0]] <= cmd.wdata;
      end
      rdata_ff <= mem[cmd.addr[AW-1:0]];
   end

   assign rdata = rdata_ff;
endmodule

FILE: hdl/c8x_bcd.sv
// ----------------------------------------------------------------------------
// c8x_bcd: byte to decimal digits
// Splits a byte into hundreds, tens and ones by constant compares and a reciprocal multiply.
// ----------------------------------------------------------------------------
module c8x_bcd import c8x_pkg::*; (
   input  logic [ByteW-1:0] value,
   output logic [ByteW-1:0] hundreds,
   output logic [ByteW-1:0] tens,
   output logic [ByteW-1:0] ones
);
   logic [ByteW-1:0] rem1;
   logic [6:0]       q10;

   // hundreds by two compares
   always_comb begin
      if (value >= 8'd200) begin
         hundreds = 8'd2;
         rem1     = value - 8'd200;
      end else if (value >= 8'd100) begin
         hundreds = 8'd1;
         rem1     = value - 8'd100;
      end else begin
         hundreds = 8'd0;
         rem1     = value;
      end
   end

   // tens by reciprocal multiply: (r*205)>>11 is exact below 100
   logic [15:0] prod;
   assign prod  = 16'(rem1) * 16'd205;
   assign q10   = 7'(prod >> 11);
   assign tens  = {1'b0, q10};
   assign ones  = rem1 - 8'(q10 * 7'd10);
endmodule

FILE: hdl/chip8_instruction_execute_core.sv
// One item in flight at a time, the next accepted the cycle after the result is taken.
// One single-port byte RAM sets the rate. Reset: synchronous; clears registers and the
// stack count, loads pc with START_ADDR, then sweeps the memory to zero before the
// first request is taken.
// ----------------------------------------------------------------------------
// chip8_instruction_execute_core: CHIP-8 execute unit top level
// Sequencer around a shared byte memory and register file.
// ----------------------------------------------------------------------------
module chip8_instruction_execute_core import c8x_pkg::*; #(
   parameter int MEM_BYTES   = MemBytesDef,
   parameter int STACK_DEPTH = StackDepthDef,
   parameter int START_ADDR  = StartAddrDef
) (
   input logic       clock,
   input logic       reset,
   c8x_req_if.sink   req,
   c8x_rsp_if.source rsp
);
   localparam int SW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_MRD, S_MWAIT, S_FH, S_FL, S_DEC,
      S_BCD, S_BLK, S_BLKW, S_DONE
   } state_type;

   state_type        state_ff, state_in;
   req_item_type     item_ff, item_in;
   logic [ByteW-1:0] regs_ff [16];
   logic [ByteW-1:0] regs_in [16];
   logic [AddrW-1:0] pc_ff, pc_in, idx_ff, idx_in;
   logic [ByteW-1:0] dly_ff, dly_in, snd_ff, snd_in;
   logic [AddrW-1:0] stack_ff [STACK_DEPTH];
   logic             push_en;
   logic [CW-1:0]    sp_ff, sp_in;
   logic [15:0]      op_ff, op_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic [1:0]       st_ff, st_in;
   logic [ByteW-1:0] rd_ff, rd_in;
   logic             rv_ff, rv_in;
   mem_cmd_type      cmd;
   logic             cmd_en;
   logic [ByteW-1:0] mrd;
   logic             clr_done;
   logic [ByteW-1:0] bh, bt, bo;

   c8x_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
      .clock(clock), .reset(reset), .cmd(cmd), .cmd_en(cmd_en),
      .rdata(mrd), .clear_done(clr_done)
   );

   logic [3:0]       ox, oy;
   logic [ByteW-1:0] kk, vx, vy;
   assign ox = op_ff[11:8];
   assign oy = op_ff[7:4];
   assign kk = op_ff[7:0];
   assign vx = regs_ff[ox];
   assign vy = regs_ff[oy];

   c8x_bcd u_bcd (.value(vx), .hundreds(bh), .tens(bt), .ones(bo));

   assign req.ready = (state_ff == S_IDLE) && !rv_ff && clr_done;
   assign rsp.valid = rv_ff;
   assign rsp.data  = '{read_data: rd_ff, pc_value: pc_ff, index_value: idx_ff,
                        delay_value: dly_ff, sound_value: snd_ff, status: st_ff};

   // sequencer
   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      regs_in  = regs_ff;
      pc_in    = pc_ff;
      idx_in   = idx_ff;
      dly_in   = dly_ff;
      snd_in   = snd_ff;
      sp_in    = sp_ff;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      st_in    = st_ff;
      rd_in    = rd_ff;
      rv_in    = rv_ff;
      push_en  = 1'b0;
      cmd_en   = 1'b0;
      cmd      = '{wr: 1'b0, addr: pc_ff, wdata: '0};
      if (rv_ff && rsp.ready) begin
         rv_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               item_in = req.data;
               st_in   = ST_OK;
               rd_in   = '0;
               case (req_kind_type'(req.data.req_type))
                  REQ_MEM_WRITE: begin
                     cmd = '{wr: 1'b1, addr: req.data.address,
                             wdata: req.data.write_data};
                     cmd_en   = 1'b1;
                     state_in = S_DONE;
                  end
                  REQ_MEM_READ: begin
                     cmd      = '{wr: 1'b0, addr: req.data.address, wdata: '0};
                     state_in = S_MRD;
                  end
                  REQ_EXECUTE: begin
                     cmd      = '{wr: 1'b0, addr: pc_ff, wdata: '0};
                     state_in = S_FH;
                  end
                  default: begin
                     rd_in    = regs_ff[req.data.reg_index];
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         // hold the read address so the byte stays on the read port
         S_MRD: begin
            cmd.addr = item_ff.address;
            state_in = S_MWAIT;
         end
         S_MWAIT: begin
            rd_in    = mrd;
            state_in = S_DONE;
         end
         // take the high byte, request the low byte
         S_FH: begin
            op_in[15:8] = mrd;
            cmd         = '{wr: 1'b0, addr: pc_ff + 1'b1, wdata: '0};
            state_in    = S_FL;
         end
         S_FL: begin
            op_in[7:0] = mrd;
            pc_in      = pc_ff + 12'd2;
            state_in   = S_DEC;
         end
         S_DEC: begin
            state_in = S_DONE;
            case (op_ff[15:12])
               4'h0: begin
                  if (op_ff != 16'h00EE) begin
                     st_in = ST_UNIMPL;
                  end else if (sp_ff == '0) begin
                     st_in = ST_UNDERFLOW;
                  end else begin
                     sp_in = sp_ff - 1'b1;
                     pc_in = stack_ff[SW'(sp_ff - 1'b1)];
                  end
               end
               4'h1: pc_in = op_ff[11:0];
               4'h2: begin
                  if (sp_ff >= CW'(STACK_DEPTH)) begin
                     st_in = ST_OVERFLOW;
                  end else begin
                     push_en = 1'b1;
                     sp_in   = sp_ff + 1'b1;
                     pc_in   = op_ff[11:0];
                  end
               end
               4'h3: if (vx == kk) pc_in = pc_ff + 12'd2;
               4'h4: if (vx != kk) pc_in = pc_ff + 12'd2;
               4'h5: if (vx == vy) pc_in = pc_ff + 12'd2;
               4'h6: regs_in[ox] = kk;
               4'h7: regs_in[ox] = vx + kk;
               4'h8: begin
                  if (op_ff[3:0] != 4'h0) st_in = ST_UNIMPL;
                  else regs_in[ox] = vy;
               end
               4'h9: if (vx != vy) pc_in = pc_ff + 12'd2;
               4'hA: idx_in = op_ff[11:0];
               4'hB: pc_in = op_ff[11:0] + AddrW'(regs_ff[0]);
               4'hC: regs_in[ox] = item_ff.random_byte & kk;
               4'hF: begin
                  case (kk)
                     8'h07: regs_in[ox] = dly_ff;
                     8'h15: dly_in = vx;
                     8'h18: snd_in = vx;
                     8'h1E: idx_in = idx_ff + AddrW'(vx);
                     8'h29: idx_in = AddrW'({vx, 2'b00}) + AddrW'(vx);
                     8'h33: begin
                        cnt_in   = '0;
                        state_in = S_BCD;
                     end
                     8'h55, 8'h65: begin
                        cnt_in   = '0;
                        state_in = S_BLK;
                     end
                     default: st_in = ST_UNIMPL;
                  endcase
               end
               default: st_in = ST_UNIMPL;
            endcase
         end
         // write three digit bytes, one per cycle
         S_BCD: begin
            cmd_en = 1'b1;
            cmd.wr = 1'b1;
            cmd.addr = idx_ff + AddrW'(cnt_ff);
            cmd.wdata = (cnt_ff == 4'd0) ? bh : (cnt_ff == 4'd1) ? bt : bo;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'd2) state_in = S_DONE;
         end
         // block move: store writes in one step, load reads then waits
         S_BLK: begin
            cmd.addr  = idx_ff + AddrW'(cnt_ff);
            cmd.wdata = regs_ff[cnt_ff];
            if (kk == 8'h55) begin
               cmd.wr = 1'b1;
               cmd_en = 1'b1;
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == ox) begin
                  idx_in   = idx_ff + AddrW'(ox) + 1'b1;
                  state_in = S_DONE;
               end
            end else begin
               state_in = S_BLKW;
            end
         end
         S_BLKW: begin
            cmd.addr = idx_ff + AddrW'(cnt_ff);
            regs_in[cnt_ff] = mrd;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ox) begin
               idx_in   = idx_ff + AddrW'(ox) + 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_BLK;
            end
         end
         S_DONE: begin
            if (!rv_ff) begin
               rv_in    = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff    <= 1'b0;
         pc_ff    <= AddrW'(START_ADDR);
         idx_ff   <= '0;
         dly_ff   <= '0;
         snd_ff   <= '0;
         sp_ff    <= '0;
         for (int i = 0; i < 16; i++) regs_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         pc_ff    <= pc_in;
         idx_ff   <= idx_in;
         dly_ff   <= dly_in;
         snd_ff   <= snd_in;
         sp_ff    <= sp_in;
         regs_ff  <= regs_in;
      end
      item_ff <= item_in;
      op_ff   <= op_in;
      cnt_ff  <= cnt_in;
      st_ff   <= st_in;
      rd_ff   <= rd_in;
   end

   // return stack, written on call
   always_ff @(posedge clock) begin
      if (push_en) begin
         stack_ff[SW'(sp_ff)] <= pc_ff;
      end
   end

   // a result is raised only from the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rv_ff) |-> $past(state_ff) == S_DONE)
      else $error("result without a completed request");
   // stack count never exceeds the depth
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= CW'(STACK_DEPTH))
      else $error("stack count out of range");
   // no request taken during clear sweep
   a_no_req_clear: assert property (@(posedge clock) disable iff (reset)
      !clr_done |-> !req.ready)
      else $error("request taken during memory clear");
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: CHIP-8 execute core
// Drives memory, register and execute requests with bursty traffic and a
// stalling receiver, predicts every response with a local model of the
// machine state, and compares each response field by field.
// ----------------------------------------------------------------------------
module testbench;
   import c8x_pkg::*;

   localparam int CycleLimit = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   c8x_req_if req_ch ();
   c8x_rsp_if rsp_ch ();

   chip8_instruction_execute_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // machine state copy
   logic [7:0]  mem_img [4096];
   logic [7:0]  vreg [16];
   logic [11:0] pc_q, idx_q;
   logic [11:0] ret_stack [16];
   int          sp_cnt;
   logic [7:0]  dly_q, snd_q;

   rsp_item_type pending_rsp [$];
   int errors = 0;
   int cycles = 0;
   int gap_left = 0;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
   end

   // compute the status of one instruction and update the state copy
   function automatic logic [1:0] run_opcode(input logic [7:0] rnd);
      logic [15:0] op;
      logic [3:0]  x, y, n;
      logic [7:0]  kk, v;
      logic [11:0] nnn;
      op  = {mem_img[pc_q], mem_img[12'(pc_q + 12'd1)]};
      x   = op[11:8];
      y   = op[7:4];
      n   = op[3:0];
      kk  = op[7:0];
      nnn = op[11:0];
      pc_q = pc_q + 12'd2;
      case (op[15:12])
         4'h0: begin
            if (op != 16'h00EE) return ST_UNIMPL;
            if (sp_cnt == 0) return ST_UNDERFLOW;
            sp_cnt--;
            pc_q = ret_stack[sp_cnt];
         end
         4'h1: pc_q = nnn;
         4'h2: begin
            if (sp_cnt >= 16) return ST_OVERFLOW;
            ret_stack[sp_cnt] = pc_q;
            sp_cnt++;
            pc_q = nnn;
         end
         4'h3: if (vreg[x] == kk) pc_q = pc_q + 12'd2;
         4'h4: if (vreg[x] != kk) pc_q = pc_q + 12'd2;
         4'h5: if (vreg[x] == vreg[y]) pc_q = pc_q + 12'd2;
         4'h6: vreg[x] = kk;
         4'h7: vreg[x] = vreg[x] + kk;
         4'h8: begin
            if (n != 4'h0) return ST_UNIMPL;
            vreg[x] = vreg[y];
         end
         4'h9: if (vreg[x] != vreg[y]) pc_q = pc_q + 12'd2;
         4'hA: idx_q = nnn;
         4'hB: pc_q = 12'(vreg[0]) + nnn;
         4'hC: vreg[x] = rnd & kk;
         4'hF: begin
            case (kk)
               8'h07: vreg[x] = dly_q;
               8'h15: dly_q = vreg[x];
               8'h18: snd_q = vreg[x];
               8'h1E: idx_q = idx_q + 12'(vreg[x]);
               8'h29: idx_q = 12'(vreg[x] * 5);
               8'h33: begin
                  v = vreg[x];
                  mem_img[idx_q] = v / 100;
                  mem_img[12'(idx_q + 12'd1)] = (v / 10) % 10;
                  mem_img[12'(idx_q + 12'd2)] = v % 10;
               end
               8'h55: begin
                  for (int i = 0; i <= x; i++) mem_img[12'(idx_q + i)] = vreg[i];
                  idx_q = idx_q + 12'(x) + 12'd1;
               end
               8'h65: begin
                  for (int i = 0; i <= x; i++) vreg[i] = mem_img[12'(idx_q + i)];
                  idx_q = idx_q + 12'(x) + 12'd1;
               end
               default: return ST_UNIMPL;
            endcase
         end
         default: return ST_UNIMPL;
      endcase
      return ST_OK;
   endfunction

   function automatic rsp_item_type predict_rsp(input req_item_type it);
      rsp_item_type r;
      r = '0;
      case (req_kind_type'(it.req_type))
         REQ_MEM_WRITE: mem_img[it.address] = it.write_data;
         REQ_MEM_READ:  r.read_data = mem_img[it.address];
         REQ_EXECUTE:   r.status = run_opcode(it.random_byte);
         default:       r.read_data = vreg[it.reg_index];
      endcase
      r.pc_value    = pc_q;
      r.index_value = idx_q;
      r.delay_value = dly_q;
      r.sound_value = snd_q;
      return r;
   endfunction

   // send one item: random gap between bursts, then hold until accepted
   task automatic send_item(input req_item_type it);
      if (gap_left == 0 && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= it;
      // look at ready away from the edge, then let the item go at the next edge
      @(negedge clock);
      while (!req_ch.ready) @(negedge clock);
      @(posedge clock);
      pending_rsp = {pending_rsp, predict_rsp(it)};
   endtask

   task automatic put_byte(input logic [11:0] a, input logic [7:0] d);
      req_item_type it;
      it = '0;
      it.req_type = REQ_MEM_WRITE;
      it.address = a;
      it.write_data = d;
      send_item(it);
   endtask

   task automatic put_word(input logic [11:0] a, input logic [15:0] w);
      put_byte(a, w[15:8]);
      put_byte(12'(a + 12'd1), w[7:0]);
   endtask

   task automatic exec_one(input logic [7:0] rnd);
      req_item_type it;
      it = '0;
      it.req_type = REQ_EXECUTE;
      it.random_byte = rnd;
      it.address = 12'($urandom);
      send_item(it);
   endtask

   // run one opcode placed at the current pc
   task automatic exec_op(input logic [15:0] w);
      put_word(pc_q, w);
      exec_one(8'($urandom));
   endtask

   task automatic test_directed();
      req_item_type it;
      it = '0;
      it.req_type = REQ_MEM_READ;
      it.address = 12'hFFF;
      send_item(it);
      put_byte(12'hFFF, 8'hFF);
      exec_op(16'h60FF);
      exec_op(16'h70FF);
      exec_op(16'h8A00);
      exec_op(16'h00EE);
      exec_op(16'h00E0);
      exec_op(16'hD123);
      exec_op(16'h2FFE);
      exec_op(16'h00EE);
      exec_op(16'hA123);
      exec_op(16'hF033);
      exec_op(16'hF029);
      exec_op(16'hFF55);
      exec_op(16'hF065);
      exec_op(16'hC3F0);
      exec_op(16'h93A1);
      exec_op(16'h5001);
      exec_op(16'hB0FF);
      exec_op(16'h1FFF);
      exec_one(8'h00);
      it.req_type = REQ_REG_READ;
      it.reg_index = 4'hF;
      send_item(it);
   endtask

   task automatic test_stack_limits();
      for (int i = 0; i < 17; i++) exec_op(16'h2000 | 16'($urandom_range(0, 4095) & 12'hFFE));
      for (int i = 0; i < 17; i++) exec_op(16'h00EE);
   endtask

   function automatic logic [15:0] pick_opcode();
      logic [15:0] w;
      w = 16'($urandom);
      case ($urandom_range(0, 11))
         0: w = 16'h00EE;
         1: w[15:12] = 4'h2;
         2: w = {4'hF, w[11:8], 8'h07};
         3: w = {4'hF, w[11:8], 8'h15};
         4: w = {4'hF, w[11:8], 8'h18};
         5: w = {4'hF, w[11:8], 8'h1E};
         6: w = {4'hF, w[11:8], 8'h29};
         7: w = {4'hF, w[11:8], 8'h33};
         8: w = {4'hF, w[11:8], ($urandom_range(0, 1) ? 8'h55 : 8'h65)};
         9: w = {4'h8, w[11:4], 4'h0};
         default: ;
      endcase
      return w;
   endfunction

   // k counts items sent: an opcode run sends three
   task automatic test_random();
      req_item_type it;
      for (int k = 0; k < 590; k++) begin
         if (gap_left > 0) gap_left--;
         else gap_left = $urandom_range(0, 12);
         if ($urandom_range(0, 3) != 0) begin
            exec_op(pick_opcode());
            k += 2;
         end else begin
            it = req_item_type'({$urandom, $urandom});
            send_item(it);
         end
      end
   endtask

   // receiver stalls on its own pattern
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(0, 99) < 70) || (cycles % 300 > 200);
   end

   // check each accepted response against the oldest prediction
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: response with none expected, actual %h", $time, rsp_ch.data);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_ch.data.read_data !== want.read_data) begin
               $display("%0t: read_data expected %h actual %h", $time,
                        want.read_data, rsp_ch.data.read_data);
               errors++;
            end
            if (rsp_ch.data.pc_value !== want.pc_value) begin
               $display("%0t: pc_value expected %h actual %h", $time,
                        want.pc_value, rsp_ch.data.pc_value);
               errors++;
            end
            if (rsp_ch.data.index_value !== want.index_value) begin
               $display("%0t: index_value expected %h actual %h", $time,
                        want.index_value, rsp_ch.data.index_value);
               errors++;
            end
            if (rsp_ch.data.delay_value !== want.delay_value) begin
               $display("%0t: delay_value expected %h actual %h", $time,
                        want.delay_value, rsp_ch.data.delay_value);
               errors++;
            end
            if (rsp_ch.data.sound_value !== want.sound_value) begin
               $display("%0t: sound_value expected %h actual %h", $time,
                        want.sound_value, rsp_ch.data.sound_value);
               errors++;
            end
            if (rsp_ch.data.status !== want.status) begin
               $display("%0t: status expected %h actual %h", $time,
                        want.status, rsp_ch.data.status);
               errors++;
            end
         end
      end
   end

   // abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < 4096; i++) mem_img[i] = '0;
      for (int i = 0; i < 16; i++) begin
         vreg[i] = '0;
         ret_stack[i] = '0;
      end
      pc_q = 12'(StartAddrDef);
      idx_q = '0;
      sp_cnt = 0;
      dly_q = '0;
      snd_q = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_stack_limits();
      test_random();
      // drop valid once the last item is taken
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

FILE: chip8_instruction_execute_core.f
hdl/c8x_pkg.sv
hdl/c8x_if.sv
hdl/c8x_mem.sv
hdl/c8x_bcd.sv
hdl/chip8_instruction_execute_core.sv
tb/testbench.sv
